// ===== sv/sxf2_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sxf2_pkg;

  // Number of architectural registers held: A X L B S T F PC SW
  localparam int SLOTS = 9;

  typedef logic [3:0] slot_t;

  // Format-2 opcodes
  localparam logic [7:0] OP_ADDR   = 8'h90;
  localparam logic [7:0] OP_SUBR   = 8'h94;
  localparam logic [7:0] OP_MULR   = 8'h98;
  localparam logic [7:0] OP_DIVR   = 8'h9C;
  localparam logic [7:0] OP_COMPR  = 8'hA0;
  localparam logic [7:0] OP_SHIFTL = 8'hA4;
  localparam logic [7:0] OP_SHIFTR = 8'hA8;
  localparam logic [7:0] OP_RMO    = 8'hAC;
  localparam logic [7:0] OP_SVC    = 8'hB0;
  localparam logic [7:0] OP_CLEAR  = 8'hB4;
  localparam logic [7:0] OP_TIXR   = 8'hB8;

  // Fault codes
  localparam logic [1:0] FAULT_OK      = 2'd0;
  localparam logic [1:0] FAULT_BAD_REG = 2'd1;
  localparam logic [1:0] FAULT_DIV0    = 2'd2;
  localparam logic [1:0] FAULT_NOT_F2  = 2'd3;

  // Register X, architectural number and storage slot
  localparam logic [3:0] X_NUMBER = 4'd1;
  localparam slot_t      X_SLOT   = 4'd1;

  typedef struct packed {
    logic  ok;
    slot_t slot;
  } slot_ref_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic start;
    logic commit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic long_op;
    logic unit_done;
  } sts_t;

  // Map an architectural register number to its storage slot
  function automatic slot_ref_t slot_of(logic [3:0] num);
    slot_ref_t r;
    r.ok   = 1'b1;
    r.slot = num;
    if (num == 4'd8) begin
      r.slot = 4'd7;
    end else if (num == 4'd9) begin
      r.slot = 4'd8;
    end else if (num > 4'd6) begin
      r.ok   = 1'b0;
      r.slot = 4'd0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/sxf2_muldiv.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sxf2_muldiv #(
  parameter int REG_WIDTH = 24
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic                 use_div,
  input  wire logic [REG_WIDTH-1:0] a,
  input  wire logic [REG_WIDTH-1:0] b,
  output logic [REG_WIDTH-1:0]      result,
  output logic                      done
);

  localparam int CW = $clog2(REG_WIDTH + 1);

  logic                 busy;
  logic [CW-1:0]        cnt;
  logic                 mode;
  logic                 neg;
  logic [REG_WIDTH-1:0] acc;
  logic [REG_WIDTH-1:0] mcand;
  logic [REG_WIDTH-1:0] mplier;

  logic [REG_WIDTH:0]   shifted;
  logic [REG_WIDTH:0]   diff;
  logic [REG_WIDTH-1:0] a_mag;
  logic [REG_WIDTH-1:0] b_mag;

  // Magnitudes of the signed divide operands
  assign a_mag = a[REG_WIDTH-1] ? (REG_WIDTH'(0) - a) : a;
  assign b_mag = b[REG_WIDTH-1] ? (REG_WIDTH'(0) - b) : b;

  // One restoring divide step: shift in the next dividend bit, trial subtract
  assign shifted = {acc, mplier[REG_WIDTH-1]};
  assign diff    = shifted - {1'b0, mcand};

  // Sequence one bit per cycle, hold the result until the next start
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CW'(REG_WIDTH);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Shared shift-add / shift-subtract datapath
  always_ff @(posedge clk) begin
    if (start) begin
      mode <= use_div;
      acc  <= '0;
      if (use_div) begin
        neg    <= a[REG_WIDTH-1] ^ b[REG_WIDTH-1];
        mcand  <= a_mag;
        mplier <= b_mag;
      end else begin
        neg    <= 1'b0;
        mcand  <= b;
        mplier <= a;
      end
    end else if (busy) begin
      if (mode) begin
        if (!diff[REG_WIDTH]) begin
          acc    <= diff[REG_WIDTH-1:0];
          mplier <= {mplier[REG_WIDTH-2:0], 1'b1};
        end else begin
          acc    <= shifted[REG_WIDTH-1:0];
          mplier <= {mplier[REG_WIDTH-2:0], 1'b0};
        end
      end else begin
        if (mplier[0]) begin
          acc <= acc + mcand;
        end
        mcand  <= {mcand[REG_WIDTH-2:0], 1'b0};
        mplier <= {1'b0, mplier[REG_WIDTH-1:1]};
      end
    end
  end

  // Product is the accumulator, quotient the shifted-in bits with sign fixup
  always_comb begin
    if (mode) begin
      result = neg ? (REG_WIDTH'(0) - mplier) : mplier;
    end else begin
      result = acc;
    end
  end

endmodule

`default_nettype wire

// ===== sv/sxf2_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sxf2_datapath #(
  parameter int REG_WIDTH = 24
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             action,
  input  wire logic [7:0]       opcode_byte,
  input  wire logic [3:0]       first_reg_field,
  input  wire logic [3:0]       second_reg_field,
  input  wire logic [23:0]      load_value,
  input  wire sxf2_pkg::cmd_t   cmd,
  output sxf2_pkg::sts_t        sts,
  output logic [3:0]            dest_register,
  output logic [23:0]           dest_value,
  output logic                  wrote,
  output logic [1:0]            fault
);

  localparam logic [5:0] W6 = 6'(REG_WIDTH);

  // Register file storage and per-entry valid bits
  logic [REG_WIDTH-1:0]       mem [sxf2_pkg::SLOTS];
  logic [sxf2_pkg::SLOTS-1:0] vld;

  // Captured item and operand reads
  logic                 f_action;
  logic [7:0]           f_op;
  logic [3:0]           f_r1;
  logic [3:0]           f_r2;
  logic [REG_WIDTH-1:0] f_lv;
  logic [REG_WIDTH-1:0] rd_a;
  logic [REG_WIDTH-1:0] rd_b;

  sxf2_pkg::slot_ref_t ref1_in;
  sxf2_pkg::slot_ref_t ref2_in;
  sxf2_pkg::slot_t     slot_a;
  sxf2_pkg::slot_ref_t ref1;
  sxf2_pkg::slot_ref_t ref2;
  sxf2_pkg::slot_ref_t ref_dest;

  // Decoded execution
  logic                 dec_wrote;
  logic [1:0]           dec_fault;
  logic [3:0]           dec_dest;
  logic [REG_WIDTH-1:0] dec_val;
  logic                 dec_mul;
  logic                 dec_div;
  logic [REG_WIDTH-1:0] res_val;

  logic [5:0]             sh_n;
  logic [5:0]             rot_s1;
  logic [5:0]             rot_s;
  logic [2*REG_WIDTH-1:0] rot_dbl;
  logic [REG_WIDTH-1:0]   sra_val;

  logic [REG_WIDTH-1:0] unit_result;
  logic                 unit_done;

  // Read addresses; TIXR reads X in the first operand slot
  assign ref1_in = sxf2_pkg::slot_of(first_reg_field);
  assign ref2_in = sxf2_pkg::slot_of(second_reg_field);
  assign slot_a  = (!action && opcode_byte == sxf2_pkg::OP_TIXR) ? sxf2_pkg::X_SLOT
                                                                  : ref1_in.slot;

  // Capture the item and read both operands
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      f_action <= action;
      f_op     <= opcode_byte;
      f_r1     <= first_reg_field;
      f_r2     <= second_reg_field;
      f_lv     <= REG_WIDTH'(load_value);
      rd_a     <= vld[slot_a] ? mem[slot_a] : '0;
      rd_b     <= vld[ref2_in.slot] ? mem[ref2_in.slot] : '0;
    end
  end

  // Write back the result at commit
  always_ff @(posedge clk) begin
    if (cmd.commit && dec_wrote) begin
      mem[ref_dest.slot] <= res_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (cmd.commit && dec_wrote) begin
      vld[ref_dest.slot] <= 1'b1;
    end
  end

  // Shift count is r2 plus one; rotate amount reduced modulo the width
  assign sh_n    = {2'b00, f_r2} + 6'd1;
  assign rot_s1  = (sh_n >= W6) ? sh_n - W6 : sh_n;
  assign rot_s   = (rot_s1 >= W6) ? rot_s1 - W6 : rot_s1;
  assign rot_dbl = {rd_a, rd_a} << rot_s;
  assign sra_val = REG_WIDTH'($signed(rd_a) >>> sh_n);

  assign ref1     = sxf2_pkg::slot_of(f_r1);
  assign ref2     = sxf2_pkg::slot_of(f_r2);
  assign ref_dest = sxf2_pkg::slot_of(dec_dest);

  // Decode the captured item
  always_comb begin
    dec_wrote = 1'b0;
    dec_fault = sxf2_pkg::FAULT_OK;
    dec_dest  = 4'd0;
    dec_val   = '0;
    dec_mul   = 1'b0;
    dec_div   = 1'b0;
    if (f_action) begin
      if (!ref1.ok) begin
        dec_fault = sxf2_pkg::FAULT_BAD_REG;
      end else begin
        dec_wrote = 1'b1;
        dec_dest  = f_r1;
        dec_val   = f_lv;
      end
    end else begin
      unique case (f_op) inside
        sxf2_pkg::OP_ADDR, sxf2_pkg::OP_SUBR, sxf2_pkg::OP_MULR,
        sxf2_pkg::OP_DIVR, sxf2_pkg::OP_RMO, sxf2_pkg::OP_COMPR: begin
          if (!ref1.ok || !ref2.ok) begin
            dec_fault = sxf2_pkg::FAULT_BAD_REG;
          end else if (f_op == sxf2_pkg::OP_COMPR) begin
            dec_wrote = 1'b0;
          end else if (f_op == sxf2_pkg::OP_DIVR && rd_a == '0) begin
            dec_fault = sxf2_pkg::FAULT_DIV0;
          end else begin
            dec_wrote = 1'b1;
            dec_dest  = f_r2;
            if (f_op == sxf2_pkg::OP_ADDR) begin
              dec_val = rd_b + rd_a;
            end else if (f_op == sxf2_pkg::OP_SUBR) begin
              dec_val = rd_b - rd_a;
            end else if (f_op == sxf2_pkg::OP_MULR) begin
              dec_mul = 1'b1;
            end else if (f_op == sxf2_pkg::OP_DIVR) begin
              dec_div = 1'b1;
            end else begin
              dec_val = rd_a;
            end
          end
        end
        sxf2_pkg::OP_CLEAR, sxf2_pkg::OP_SHIFTL, sxf2_pkg::OP_SHIFTR,
        sxf2_pkg::OP_TIXR: begin
          if (!ref1.ok) begin
            dec_fault = sxf2_pkg::FAULT_BAD_REG;
          end else begin
            dec_wrote = 1'b1;
            dec_dest  = f_r1;
            if (f_op == sxf2_pkg::OP_SHIFTL) begin
              dec_val = rot_dbl[2*REG_WIDTH-1:REG_WIDTH];
            end else if (f_op == sxf2_pkg::OP_SHIFTR) begin
              dec_val = sra_val;
            end else if (f_op == sxf2_pkg::OP_TIXR) begin
              dec_dest = sxf2_pkg::X_NUMBER;
              dec_val  = rd_a + REG_WIDTH'(1);
            end
          end
        end
        sxf2_pkg::OP_SVC: begin
          dec_wrote = 1'b0;
        end
        default: begin
          dec_fault = sxf2_pkg::FAULT_NOT_F2;
        end
      endcase
    end
  end

  // Multiply and divide go through the shared iterative unit
  sxf2_muldiv #(
    .REG_WIDTH(REG_WIDTH)
  ) u_muldiv (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.start),
    .use_div (dec_div),
    .a       (rd_a),
    .b       (rd_b),
    .result  (unit_result),
    .done    (unit_done)
  );

  assign res_val       = (dec_mul || dec_div) ? unit_result : dec_val;
  assign sts.long_op   = dec_mul || dec_div;
  assign sts.unit_done = unit_done;

  // Load the result item
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      dest_register <= dec_dest;
      dest_value    <= 24'(res_val);
      wrote         <= dec_wrote;
      fault         <= dec_fault;
    end
  end

endmodule

`default_nettype wire

// ===== sv/sxf2_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sxf2_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  output logic                item_stall,
  output logic                result_valid,
  input  wire logic           result_stall,
  output sxf2_pkg::cmd_t      cmd,
  input  wire sxf2_pkg::sts_t sts
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_ITER
  } state_t;

  state_t state;
  logic   out_free;

  // Output register can take a result this cycle
  assign out_free   = !result_valid || !result_stall;
  assign item_stall = (state != S_IDLE);

  // Commands to the datapath
  always_comb begin
    cmd.capture = (state == S_IDLE) && item_valid;
    cmd.start   = (state == S_EXEC) && sts.long_op;
    cmd.commit  = out_free &&
                  (((state == S_EXEC) && !sts.long_op) ||
                   ((state == S_ITER) && sts.unit_done));
  end

  // State and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (sts.long_op) begin
            state <= S_ITER;
          end else if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_ITER: begin
          if (sts.unit_done && out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // An accepted item is decoded in the next cycle
  a_capture_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (state == S_EXEC))
    else $error("accepted item did not move to execute");

  // A new result appears only after a commit
  a_valid_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(cmd.commit))
    else $error("result valid rose without a commit");

  // Starting the unit clears its done flag
  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> !sts.unit_done)
    else $error("unit done still set after start");

  // A commit never overwrites a stalled result
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> !$past(cmd.commit))
    else $error("commit while result stalled");

endmodule

`default_nettype wire

// ===== sv/sicxe_format2_register_unit.sv =====
// SIC/XE format-2 register unit.
// Input channel: item_valid / item_stall carry one item (action, opcode_byte,
// first_reg_field, second_reg_field, load_value). An item is taken at a clock
// edge with item_valid high and item_stall low. Output channel: result_valid /
// result_stall carry one result item (dest_register, dest_value, wrote, fault)
// for every input item, in order.
// One item is worked on at a time. Loads, faults and the other register
// operations read the register file when the item is taken, then decode,
// compute and write back in the execute state.
// MULR and DIVR run on the shared multiply/divide unit, which retires one
// bit per cycle. The register file read is registered, so an item sees the
// write of the item before it.
// A result that waits under result_stall is held; the next item may still
// be accepted and runs up to its write back, which waits for the output
// register to free up.
// Synchronous reset clears all registers to zero through per-register
// valid bits and empties both channels; items are taken in the next cycle.
`timescale 1ns / 1ps
`default_nettype none

module sicxe_format2_register_unit #(
  parameter int REG_WIDTH = 24
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic        action,
  input  wire logic [7:0]  opcode_byte,
  input  wire logic [3:0]  first_reg_field,
  input  wire logic [3:0]  second_reg_field,
  input  wire logic [23:0] load_value,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [3:0]       dest_register,
  output logic [23:0]      dest_value,
  output logic             wrote,
  output logic [1:0]       fault
);

  sxf2_pkg::cmd_t cmd;
  sxf2_pkg::sts_t sts;

  // Sequencing
  sxf2_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd),
    .sts          (sts)
  );

  // Register file and execution
  sxf2_datapath #(
    .REG_WIDTH(REG_WIDTH)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .action           (action),
    .opcode_byte      (opcode_byte),
    .first_reg_field  (first_reg_field),
    .second_reg_field (second_reg_field),
    .load_value       (load_value),
    .cmd              (cmd),
    .sts              (sts),
    .dest_register    (dest_register),
    .dest_value       (dest_value),
    .wrote            (wrote),
    .fault            (fault)
  );

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int RW             = 24;
  localparam int RANDOM_ITEMS   = 1000;
  localparam int HOLD_CYCLES    = 300;
  localparam int HOLD_AFTER     = 150;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 3000;

  localparam logic ACT_EXEC = 1'b0;
  localparam logic ACT_LOAD = 1'b1;

  // Architectural register numbers
  localparam logic [3:0] REG_A   = 4'd0;
  localparam logic [3:0] REG_X   = 4'd1;
  localparam logic [3:0] REG_L   = 4'd2;
  localparam logic [3:0] REG_B   = 4'd3;
  localparam logic [3:0] REG_S   = 4'd4;
  localparam logic [3:0] REG_T   = 4'd5;
  localparam logic [3:0] REG_F   = 4'd6;
  localparam logic [3:0] REG_GAP = 4'd7;
  localparam logic [3:0] REG_PC  = 4'd8;
  localparam logic [3:0] REG_SW  = 4'd9;
  localparam logic [3:0] REG_TEN = 4'd10;
  localparam logic [3:0] REG_TOP = 4'd15;

  // Receiver stall patterns
  localparam int STALL_NONE  = 0;
  localparam int STALL_HALF  = 1;
  localparam int STALL_HEAVY = 2;
  localparam int STALL_ALT   = 3;

  typedef struct packed {
    logic        action;
    logic [7:0]  opcode_byte;
    logic [3:0]  first_reg_field;
    logic [3:0]  second_reg_field;
    logic [23:0] load_value;
  } f2_item_t;

  typedef struct packed {
    logic [3:0]  dest_register;
    logic [23:0] dest_value;
    logic        wrote;
    logic [1:0]  fault;
  } f2_result_t;

  typedef struct packed {
    f2_item_t   item;
    logic       typed;
    f2_result_t result;
  } directed_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic        action = 1'b0;
  logic [7:0]  opcode_byte = '0;
  logic [3:0]  first_reg_field = '0;
  logic [3:0]  second_reg_field = '0;
  logic [23:0] load_value = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [3:0]  dest_register;
  logic [23:0] dest_value;
  logic        wrote;
  logic [1:0]  fault;

  logic [RW-1:0] shadow_regs [sxf2_pkg::SLOTS];
  f2_result_t    pending_results [$];
  directed_row_t directed_rows [$];
  int            items_sent = 0;
  int            mismatches = 0;
  int            quiet_cycles = 0;

  sicxe_format2_register_unit uut (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .action           (action),
    .opcode_byte      (opcode_byte),
    .first_reg_field  (first_reg_field),
    .second_reg_field (second_reg_field),
    .load_value       (load_value),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .dest_register    (dest_register),
    .dest_value       (dest_value),
    .wrote            (wrote),
    .fault            (fault)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Map a register number to its storage slot, -1 for no register
  function automatic int reg_slot(input logic [3:0] num);
    if (num <= REG_F) return int'(num);
    if (num == REG_PC) return 7;
    if (num == REG_SW) return 8;
    return -1;
  endfunction

  // Execute one item on the shadow registers and return its result
  function automatic f2_result_t execute_f2(input f2_item_t it);
    f2_result_t    res;
    int            s1;
    int            s2;
    int            n;
    logic [RW-1:0] a;
    logic [RW-1:0] b;
    logic [RW-1:0] ma;
    logic [RW-1:0] mb;
    logic [RW-1:0] q;
    logic [RW-1:0] v;
    logic [2*RW-1:0] twice;
    logic [3:0]    dnum;
    bit            write;
    res   = '0;
    write = 1'b0;
    dnum  = '0;
    v     = '0;
    s1 = reg_slot(it.first_reg_field);
    s2 = reg_slot(it.second_reg_field);
    a = (s1 >= 0) ? shadow_regs[s1] : '0;
    b = (s2 >= 0) ? shadow_regs[s2] : '0;
    n = int'(it.second_reg_field) + 1;
    if (it.action == ACT_LOAD) begin
      if (s1 < 0) begin
        res.fault = sxf2_pkg::FAULT_BAD_REG;
      end else begin
        write = 1'b1;
        dnum  = it.first_reg_field;
        v     = it.load_value[RW-1:0];
      end
    end else begin
      case (it.opcode_byte)
        sxf2_pkg::OP_ADDR, sxf2_pkg::OP_SUBR, sxf2_pkg::OP_MULR, sxf2_pkg::OP_DIVR,
        sxf2_pkg::OP_RMO, sxf2_pkg::OP_COMPR: begin
          if (s1 < 0 || s2 < 0) begin
            res.fault = sxf2_pkg::FAULT_BAD_REG;
          end else if (it.opcode_byte == sxf2_pkg::OP_COMPR) begin
            // compare is not modeled: no write, no fault
          end else if (it.opcode_byte == sxf2_pkg::OP_DIVR && a == '0) begin
            res.fault = sxf2_pkg::FAULT_DIV0;
          end else begin
            write = 1'b1;
            dnum  = it.second_reg_field;
            case (it.opcode_byte)
              sxf2_pkg::OP_ADDR: v = b + a;
              sxf2_pkg::OP_SUBR: v = b - a;
              sxf2_pkg::OP_MULR: v = b * a;
              sxf2_pkg::OP_DIVR: begin
                // divide magnitudes, then fix the sign
                ma = a[RW-1] ? -a : a;
                mb = b[RW-1] ? -b : b;
                q  = mb / ma;
                v  = (a[RW-1] ^ b[RW-1]) ? -q : q;
              end
              default: v = a;
            endcase
          end
        end
        sxf2_pkg::OP_CLEAR, sxf2_pkg::OP_SHIFTL, sxf2_pkg::OP_SHIFTR,
        sxf2_pkg::OP_TIXR: begin
          if (s1 < 0) begin
            res.fault = sxf2_pkg::FAULT_BAD_REG;
          end else begin
            write = 1'b1;
            dnum  = it.first_reg_field;
            case (it.opcode_byte)
              sxf2_pkg::OP_CLEAR: v = '0;
              sxf2_pkg::OP_SHIFTL: begin
                twice = {a, a} << (n % RW);
                v = twice[2*RW-1:RW];
              end
              sxf2_pkg::OP_SHIFTR: begin
                if (n >= RW) v = {RW{a[RW-1]}};
                else v = $signed(a) >>> n;
              end
              default: begin
                dnum = sxf2_pkg::X_NUMBER;
                v    = shadow_regs[sxf2_pkg::X_SLOT] + RW'(1);
              end
            endcase
          end
        end
        sxf2_pkg::OP_SVC: begin
          // supervisor call is not modeled
        end
        default: res.fault = sxf2_pkg::FAULT_NOT_F2;
      endcase
    end
    if (write) begin
      shadow_regs[reg_slot(dnum)] = v;
      res.dest_register = dnum;
      res.dest_value    = v;
      res.wrote         = 1'b1;
    end
    return res;
  endfunction

  function automatic logic [7:0] f2_opcode(input int k);
    case (k)
      0:       return sxf2_pkg::OP_ADDR;
      1:       return sxf2_pkg::OP_SUBR;
      2:       return sxf2_pkg::OP_MULR;
      3:       return sxf2_pkg::OP_DIVR;
      4:       return sxf2_pkg::OP_COMPR;
      5:       return sxf2_pkg::OP_SHIFTL;
      6:       return sxf2_pkg::OP_SHIFTR;
      7:       return sxf2_pkg::OP_RMO;
      8:       return sxf2_pkg::OP_SVC;
      9:       return sxf2_pkg::OP_CLEAR;
      default: return sxf2_pkg::OP_TIXR;
    endcase
  endfunction

  // Mostly a real register, now and then any number
  function automatic logic [3:0] pick_reg();
    int k;
    k = $urandom_range(0, 99);
    if (k >= 92) return 4'($urandom_range(0, 15));
    k = $urandom_range(0, sxf2_pkg::SLOTS - 1);
    if (k == 7) return REG_PC;
    if (k == 8) return REG_SW;
    return 4'(k);
  endfunction

  function automatic logic [23:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      2:       return 24'h800000;
      3:       return 24'h7FFFFF;
      4:       return 24'h000001;
      5:       return 24'($urandom_range(0, 255));
      default: return 24'($urandom);
    endcase
  endfunction

  // Mostly well-formed instructions and loads, the rest random bytes
  function automatic f2_item_t random_item();
    f2_item_t it;
    int       pick;
    pick = $urandom_range(0, 99);
    it.action           = ACT_EXEC;
    it.opcode_byte      = 8'($urandom_range(0, 255));
    it.first_reg_field  = pick_reg();
    it.second_reg_field = pick_reg();
    it.load_value       = pick_value();
    if (pick < 25) begin
      it.action = ACT_LOAD;
    end else if (pick < 90) begin
      it.opcode_byte = f2_opcode($urandom_range(0, 10));
      if (it.opcode_byte == sxf2_pkg::OP_SHIFTL || it.opcode_byte == sxf2_pkg::OP_SHIFTR)
        it.second_reg_field = 4'($urandom_range(0, 15));
    end else begin
      it.first_reg_field  = 4'($urandom_range(0, 15));
      it.second_reg_field = 4'($urandom_range(0, 15));
    end
    return it;
  endfunction

  task automatic add_row(input logic act, input logic [7:0] op, input logic [3:0] r1,
                         input logic [3:0] r2, input logic [23:0] lv, input logic typed,
                         input logic [3:0] dr, input logic [23:0] dv, input logic w,
                         input logic [1:0] f);
    directed_row_t row;
    row.item   = '{act, op, r1, r2, lv};
    row.typed  = typed;
    row.result = '{dr, dv, w, f};
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // Offer one item, hold it until taken, then record its expected result
  task automatic offer(input f2_item_t it, input logic typed, input f2_result_t typed_res);
    f2_result_t predicted;
    item_valid       <= 1'b1;
    action           <= it.action;
    opcode_byte      <= it.opcode_byte;
    first_reg_field  <= it.first_reg_field;
    second_reg_field <= it.second_reg_field;
    load_value       <= it.load_value;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predicted = execute_f2(it);
    pending_results.insert(pending_results.size(), typed ? typed_res : predicted);
    items_sent++;
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic compare_field(input string name, input logic [23:0] want,
                               input logic [23:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Check every result taken against the oldest expectation
  always @(posedge clk) begin : check_results
    f2_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: dest_register %0d dest_value %0h wrote %0b fault %0d",
               dest_register, dest_value, wrote, fault);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        compare_field("dest_register", 24'(want.dest_register), 24'(dest_register));
        compare_field("dest_value", want.dest_value, dest_value);
        compare_field("wrote", 24'(want.wrote), 24'(wrote));
        compare_field("fault", 24'(want.fault), 24'(fault));
      end
    end
  end

  // End the run if nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Receiver: shifting stall patterns, one long hold-off
  initial begin : receiver
    int  stall_mode;
    int  span;
    int  phase;
    bit  held_off;
    held_off = 1'b0;
    phase    = 0;
    wait (!rst);
    forever begin
      if (!held_off && items_sent >= HOLD_AFTER) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        held_off = 1'b1;
      end
      stall_mode = $urandom_range(STALL_NONE, STALL_ALT);
      span       = $urandom_range(5, 60);
      repeat (span) begin
        case (stall_mode)
          STALL_NONE:  result_stall <= 1'b0;
          STALL_HALF:  result_stall <= ($urandom_range(0, 1) == 1);
          STALL_HEAVY: result_stall <= ($urandom_range(0, 4) != 0);
          default:     result_stall <= phase[0];
        endcase
        phase++;
        @(posedge clk);
      end
    end
  end

  // Sender: directed table, then random bursts
  initial begin : sender
    int k;
    int burst;
    int gap;
    foreach (shadow_regs[i]) shadow_regs[i] = '0;

    // after reset, extremes, special cases
    add_row(ACT_EXEC, sxf2_pkg::OP_ADDR, REG_A, REG_X, 24'h0, 1, REG_X, 24'h0, 1,
            sxf2_pkg::FAULT_OK);
    add_row(ACT_LOAD, 8'hFF, REG_A, REG_TOP, 24'hFFFFFF, 1, REG_A, 24'hFFFFFF, 1,
            sxf2_pkg::FAULT_OK);
    add_row(ACT_LOAD, 8'h00, REG_SW, REG_A, 24'h800000, 1, REG_SW, 24'h800000, 1,
            sxf2_pkg::FAULT_OK);
    add_row(ACT_LOAD, sxf2_pkg::OP_ADDR, REG_PC, REG_A, 24'h000001, 1, REG_PC, 24'h1, 1,
            sxf2_pkg::FAULT_OK);
    add_row(ACT_LOAD, sxf2_pkg::OP_TIXR, REG_X, REG_X, 24'hFFFFFF, 1, REG_X, 24'hFFFFFF, 1,
            sxf2_pkg::FAULT_OK);
    add_row(ACT_LOAD, sxf2_pkg::OP_ADDR, REG_GAP, REG_A, 24'h123456, 1, 4'd0, 24'h0, 0,
            sxf2_pkg::FAULT_BAD_REG);
    add_row(ACT_LOAD, 8'hFF, REG_TOP, REG_TOP, 24'hFFFFFF, 1, 4'd0, 24'h0, 0,
            sxf2_pkg::FAULT_BAD_REG);
    add_row(ACT_EXEC, 8'h00, REG_A, REG_A, 24'h0, 1, 4'd0, 24'h0, 0,
            sxf2_pkg::FAULT_NOT_F2);
    add_row(ACT_EXEC, 8'hFF, REG_TOP, REG_TOP, 24'hFFFFFF, 1, 4'd0, 24'h0, 0,
            sxf2_pkg::FAULT_NOT_F2);
    add_row(ACT_EXEC, sxf2_pkg::OP_ADDR, REG_GAP, REG_A, 24'h0, 1, 4'd0, 24'h0, 0,
            sxf2_pkg::FAULT_BAD_REG);
    add_row(ACT_EXEC, sxf2_pkg::OP_DIVR, REG_T, REG_A, 24'h0, 1, 4'd0, 24'h0, 0,
            sxf2_pkg::FAULT_DIV0);
    // bad register wins over a zero divisor
    add_row(ACT_EXEC, sxf2_pkg::OP_DIVR, REG_T, REG_TOP, 24'h0, 1, 4'd0, 24'h0, 0,
            sxf2_pkg::FAULT_BAD_REG);
    add_row(ACT_EXEC, sxf2_pkg::OP_COMPR, REG_A, REG_SW, 24'h0, 1, 4'd0, 24'h0, 0,
            sxf2_pkg::FAULT_OK);
    add_row(ACT_EXEC, sxf2_pkg::OP_COMPR, REG_A, REG_TEN, 24'h0, 1, 4'd0, 24'h0, 0,
            sxf2_pkg::FAULT_BAD_REG);
    add_row(ACT_EXEC, sxf2_pkg::OP_SVC, REG_TOP, REG_TOP, 24'h0, 1, 4'd0, 24'h0, 0,
            sxf2_pkg::FAULT_OK);
    // most negative divided by minus one wraps
    add_row(ACT_EXEC, sxf2_pkg::OP_DIVR, REG_X, REG_SW, 24'h0, 0, 4'd0, 24'h0, 0,
            sxf2_pkg::FAULT_OK);
    add_row(ACT_EXEC, sxf2_pkg::OP_ADDR, REG_A, REG_L, 24'h0, 0, 4'd0, 24'h0, 0,
            sxf2_pkg::FAULT_OK);
    add_row(ACT_EXEC, sxf2_pkg::OP_SUBR, REG_PC, REG_L, 24'h0, 0, 4'd0, 24'h0, 0,
            sxf2_pkg::FAULT_OK);
    add_row(ACT_EXEC, sxf2_pkg::OP_MULR, REG_A, REG_L, 24'h0, 0, 4'd0, 24'h0, 0,
            sxf2_pkg::FAULT_OK);
    add_row(ACT_EXEC, sxf2_pkg::OP_RMO, REG_SW, REG_B, 24'h0, 0, 4'd0, 24'h0, 0,
            sxf2_pkg::FAULT_OK);
    add_row(ACT_EXEC, sxf2_pkg::OP_SHIFTL, REG_A, REG_TOP, 24'h0, 0, 4'd0, 24'h0, 0,
            sxf2_pkg::FAULT_OK);
    add_row(ACT_EXEC, sxf2_pkg::OP_SHIFTR, REG_SW, REG_TOP, 24'h0, 0, 4'd0, 24'h0, 0,
            sxf2_pkg::FAULT_OK);
    add_row(ACT_EXEC, sxf2_pkg::OP_CLEAR, REG_A, REG_TOP, 24'hFFFFFF, 1, REG_A, 24'h0, 1,
            sxf2_pkg::FAULT_OK);
    add_row(ACT_EXEC, sxf2_pkg::OP_TIXR, REG_S, REG_TOP, 24'h0, 0, 4'd0, 24'h0, 0,
            sxf2_pkg::FAULT_OK);
    add_row(ACT_EXEC, sxf2_pkg::OP_TIXR, 4'd12, REG_A, 24'h0, 1, 4'd0, 24'h0, 0,
            sxf2_pkg::FAULT_BAD_REG);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[j])
      offer(directed_rows[j].item, directed_rows[j].typed, directed_rows[j].result);
    drain();

    burst = 0;
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      // pause once until everything has come back
      if (k == RANDOM_ITEMS / 2) begin
        drain();
      end else if (burst == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          item_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst = $urandom_range(1, 24);
      end
      offer(random_item(), 1'b0, '0);
      if (burst > 0) burst--;
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/sxf2_pkg.sv
sv/sxf2_muldiv.sv
sv/sxf2_datapath.sv
sv/sxf2_ctrl.sv
sv/sicxe_format2_register_unit.sv
bench/tb.sv
